// ----- sv/krt_pkg.sv -----
// Shared types and helpers for the keyed record table.
// Holds the request and status codes, controller states, the command and
// status structs between controller and datapath, and string trimming functions.
`default_nettype none

package krt_pkg;

    localparam int KEY_W   = 80;
    localparam int LABEL_W = 160;
    localparam int PRICE_W = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_DELETE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_DUP     = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EXEC,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESPOND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic idx_clr;
        logic idx_inc;
        logic rd_scan;
        logic rd_shift;
        logic set_hit;
        logic exec;
        logic wr_insert;
        logic wr_price;
        logic wr_shift;
        logic cnt_inc;
        logic cnt_dec;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  hit;
        logic  full;
        logic  scan_end;
        logic  shift_end;
        logic  key_match;
        logic  out_busy;
    } stat_t;

    // Clears every byte after the first zero byte of a key.
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] r;
        logic             ended;
        r     = v;
        ended = 1'b0;
        for (int i = 0; i < KEY_W / 8; i++) begin
            if (ended) begin
                r[i*8 +: 8] = 8'd0;
            end else if (v[i*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
        end
        return r;
    endfunction

    // Same trimming for the label.
    function automatic logic [LABEL_W-1:0] trim_label(input logic [LABEL_W-1:0] v);
        logic [LABEL_W-1:0] r;
        logic               ended;
        r     = v;
        ended = 1'b0;
        for (int i = 0; i < LABEL_W / 8; i++) begin
            if (ended) begin
                r[i*8 +: 8] = 8'd0;
            end else if (v[i*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/krt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package dependencies.
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/krt_ctrl.sv -----
// Controller state machine of the keyed record table.
// Depends on krt_pkg for state, mode, command and status types.
`default_nettype none

module krt_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire krt_pkg::stat_t stat,
    output krt_pkg::cmd_t       cmd
);

    krt_pkg::state_t state_reg;
    krt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= krt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            krt_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = krt_pkg::ST_SCAN_RD;
                end
            end
            krt_pkg::ST_SCAN_RD: begin
                if (stat.scan_end) begin
                    state_next = krt_pkg::ST_EXEC;
                end else begin
                    cmd.rd_scan = 1'b1;
                    state_next  = krt_pkg::ST_SCAN_CMP;
                end
            end
            krt_pkg::ST_SCAN_CMP: begin
                if (stat.key_match) begin
                    cmd.set_hit = 1'b1;
                    state_next  = krt_pkg::ST_EXEC;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = krt_pkg::ST_SCAN_RD;
                end
            end
            krt_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = krt_pkg::ST_RESPOND;
                case (stat.mode)
                    krt_pkg::MODE_INSERT: begin
                        if (!stat.full && !stat.hit) begin
                            cmd.wr_insert = 1'b1;
                            cmd.cnt_inc   = 1'b1;
                        end
                    end
                    krt_pkg::MODE_UPDATE: begin
                        cmd.wr_price = stat.hit;
                    end
                    krt_pkg::MODE_DELETE: begin
                        if (stat.hit) begin
                            state_next = krt_pkg::ST_SHIFT_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            krt_pkg::ST_SHIFT_RD: begin
                if (stat.shift_end) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = krt_pkg::ST_RESPOND;
                end else begin
                    cmd.rd_shift = 1'b1;
                    state_next   = krt_pkg::ST_SHIFT_WR;
                end
            end
            krt_pkg::ST_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = krt_pkg::ST_SHIFT_RD;
            end
            krt_pkg::ST_RESPOND: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = krt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = krt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/krt_dp.sv -----
// Datapath of the keyed record table: request registers, record RAMs,
// index and count registers, result and output registers.
// Depends on krt_pkg and krt_ram.
`default_nettype none

module krt_dp #(
    parameter int CAPACITY = 128,
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W = $clog2(CAPACITY + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire krt_pkg::cmd_t       cmd,
    output krt_pkg::stat_t           stat,
    input  wire logic [1:0]          s_mode,
    input  wire logic [15:0]         s_key_head,
    input  wire logic [63:0]         s_key_tail,
    input  wire logic [63:0]         s_label_part_a,
    input  wire logic [63:0]         s_label_part_b,
    input  wire logic [31:0]         s_label_part_c,
    input  wire logic signed [31:0]  s_price_in,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic [63:0]              m_label_out_a,
    output logic [63:0]              m_label_out_b,
    output logic [31:0]              m_label_out_c,
    output logic signed [31:0]       m_price_out,
    output logic [7:0]               m_entry_count_out
);

    localparam int KW = krt_pkg::KEY_W;
    localparam int LW = krt_pkg::LABEL_W;
    localparam int PW = krt_pkg::PRICE_W;

    krt_pkg::mode_t   mode_reg;
    logic [KW-1:0]    key_reg;
    logic [LW-1:0]    label_reg;
    logic [PW-1:0]    price_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             hit_reg;

    logic [1:0]       res_status_reg;
    logic [LW-1:0]    res_label_reg;
    logic [PW-1:0]    res_price_reg;
    krt_pkg::status_t res_status_next;

    logic             m_valid_reg;
    logic             m_valid_next;
    logic [1:0]       m_status_reg;
    logic [LW-1:0]    m_label_reg;
    logic [PW-1:0]    m_price_reg;
    logic [7:0]       m_count_reg;

    logic [CNT_W-1:0] idx_plus1;
    logic [CNT_W+7:0] count_wide;
    logic [KW-1:0]    key_rd;
    logic [LW-1:0]    label_rd;
    logic [PW-1:0]    price_rd;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             rec_we;
    logic             price_we;
    logic [KW-1:0]    key_wr;
    logic [LW-1:0]    label_wr;
    logic [PW-1:0]    price_wr;

    assign idx_plus1 = idx_reg + CNT_W'(1);

    // Record RAM ports.
    assign rd_en    = cmd.rd_scan | cmd.rd_shift;
    assign rd_addr  = cmd.rd_shift ? idx_plus1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_addr  = cmd.wr_insert ? count_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign rec_we   = cmd.wr_insert | cmd.wr_shift;
    assign price_we = cmd.wr_insert | cmd.wr_shift | cmd.wr_price;
    assign key_wr   = cmd.wr_shift ? key_rd : key_reg;
    assign label_wr = cmd.wr_shift ? label_rd : label_reg;
    assign price_wr = cmd.wr_shift ? price_rd : price_reg;

    krt_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
        .aclk    (aclk),
        .we      (rec_we),
        .wr_addr (wr_addr),
        .wr_data (key_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (key_rd)
    );

    krt_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_label_ram (
        .aclk    (aclk),
        .we      (rec_we),
        .wr_addr (wr_addr),
        .wr_data (label_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (label_rd)
    );

    krt_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_price_ram (
        .aclk    (aclk),
        .we      (price_we),
        .wr_addr (wr_addr),
        .wr_data (price_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (price_rd)
    );

    // Status toward the controller.
    assign stat.mode      = mode_reg;
    assign stat.hit       = hit_reg;
    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign stat.scan_end  = (idx_reg >= count_reg);
    assign stat.shift_end = (idx_plus1 >= count_reg);
    assign stat.key_match = (key_rd == key_reg);
    assign stat.out_busy  = m_valid_reg & ~m_ready;

    always_comb begin
        if (mode_reg == krt_pkg::MODE_INSERT) begin
            if (stat.full) begin
                res_status_next = krt_pkg::STAT_FULL;
            end else if (hit_reg) begin
                res_status_next = krt_pkg::STAT_DUP;
            end else begin
                res_status_next = krt_pkg::STAT_DONE;
            end
        end else begin
            res_status_next = hit_reg ? krt_pkg::STAT_DONE : krt_pkg::STAT_MISSING;
        end
    end

    // Request capture (trimmed so that bytes after a terminator read as zero), index, result and output registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            mode_reg  <= krt_pkg::mode_t'(s_mode);
            key_reg   <= krt_pkg::trim_key({s_key_tail, s_key_head});
            label_reg <= krt_pkg::trim_label({s_label_part_c, s_label_part_b,
                                              s_label_part_a});
            price_reg <= s_price_in;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_plus1;
        end
        if (cmd.exec) begin
            res_status_reg <= res_status_next;
            if (mode_reg == krt_pkg::MODE_FIND && hit_reg) begin
                res_label_reg <= label_rd;
                res_price_reg <= price_rd;
            end else begin
                res_label_reg <= '0;
                res_price_reg <= '0;
            end
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_label_reg  <= res_label_reg;
            m_price_reg  <= res_price_reg;
            m_count_reg  <= count_wide[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.load_req) begin
                hit_reg <= 1'b0;
            end else if (cmd.set_hit) begin
                hit_reg <= 1'b1;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assign count_wide   = {8'd0, count_reg};
    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_label_out_a     = m_label_reg[63:0];
    assign m_label_out_b     = m_label_reg[127:64];
    assign m_label_out_c     = m_label_reg[159:128];
    assign m_price_out       = m_price_reg;
    assign m_entry_count_out = m_count_reg;

endmodule

`default_nettype wire

// ----- sv/keyed_record_table.sv -----
// Keyed record table: the controller does a linear key scan (one RAM read and one
// compare per entry), then executes; a delete then shifts every later entry down
// through the same RAMs, one read and one write per entry. One item is in work at
// a time; the next item is taken while a finished result still waits in the output
// register. Reset (aresetn, synchronous, active low) empties the table at once; no
// clearing pass.
`default_nettype none

module keyed_record_table #(
    parameter int CAPACITY = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Request channel.
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_mode,
    input  wire logic [15:0]        s_key_head,
    input  wire logic [63:0]        s_key_tail,
    input  wire logic [63:0]        s_label_part_a,
    input  wire logic [63:0]        s_label_part_b,
    input  wire logic [31:0]        s_label_part_c,
    input  wire logic signed [31:0] s_price_in,
    // Result channel.
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [63:0]             m_label_out_a,
    output logic [63:0]             m_label_out_b,
    output logic [31:0]             m_label_out_c,
    output logic signed [31:0]      m_price_out,
    output logic [7:0]              m_entry_count_out
);

    // The controller walks each request through scan, execute, optional
    // shift-down and respond. The datapath owns all storage: the three record
    // RAMs (key, label, price), the scan index, the entry count and the
    // output register that decouples the result channel from the request side.
    krt_pkg::cmd_t  cmd;
    krt_pkg::stat_t stat;

    krt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Keys and labels are trimmed at capture so that every byte after the
    // first zero byte is zero; matching then reduces to a plain equality test
    // against each stored key, and stored labels come back already trimmed.
    krt_dp #(.CAPACITY(CAPACITY)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_mode            (s_mode),
        .s_key_head        (s_key_head),
        .s_key_tail        (s_key_tail),
        .s_label_part_a    (s_label_part_a),
        .s_label_part_b    (s_label_part_b),
        .s_label_part_c    (s_label_part_c),
        .s_price_in        (s_price_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_label_out_a     (m_label_out_a),
        .m_label_out_b     (m_label_out_b),
        .m_label_out_c     (m_label_out_c),
        .m_price_out       (m_price_out),
        .m_entry_count_out (m_entry_count_out)
    );

endmodule

`default_nettype wire
